FILE: rtl/core/fmssn_pkg.sv
// Shared types and constants for the mantissa shift / normalize datapath.
`timescale 1ns / 1ps
`default_nettype none
package fmssn_pkg;

    // Word geometry of the internal mantissa
    localparam int MANT_W     = 32;
    localparam int MANT_WORDS = 4;
    localparam int MANT_TOT   = MANT_WORDS * MANT_W;
    localparam int SH_W       = $clog2(MANT_W);

    // Exponent: port width and internal width with headroom for the adjust
    localparam int EXP_W     = 16;
    localparam int EXP_INT_W = EXP_W + 2;

    // Default configuration
    localparam int MANT_BITS_DEF = 115;
    localparam int LEAD_BIT_DEF  = 18;

    // Operation codes
    typedef enum logic {
        REQ_SHIFT = 1'b0,
        REQ_NORM  = 1'b1
    } t_req;

    // Pipeline stage contents
    typedef struct packed {
        t_req                        req;
        logic                        zero;
        logic                        sticky;
        logic signed [EXP_INT_W-1:0] exp;
        logic                        right;
        logic [SH_W-1:0]             shamt;
        logic [MANT_TOT-1:0]         mant;
    } t_stage;

endpackage
`default_nettype wire

FILE: rtl/core/fmssn_in_if.sv
// Input channel: request beat with operation, shift count and number.
`timescale 1ns / 1ps
`default_nettype none
interface fmssn_in_if;
    import fmssn_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic [7:0]              shift_amount;
    logic [MANT_W-1:0]       mant_word0;
    logic [MANT_W-1:0]       mant_word1;
    logic [MANT_W-1:0]       mant_word2;
    logic [MANT_W-1:0]       mant_word3;
    logic                    sticky_in;
    logic signed [EXP_W-1:0] exponent_in;

    modport source (
        output valid, req_type, shift_amount, mant_word0, mant_word1,
               mant_word2, mant_word3, sticky_in, exponent_in,
        input  ready
    );
    modport sink (
        input  valid, req_type, shift_amount, mant_word0, mant_word1,
               mant_word2, mant_word3, sticky_in, exponent_in,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/core/fmssn_out_if.sv
// Output channel: result beat with mantissa, sticky, exponent and zero flag.
`timescale 1ns / 1ps
`default_nettype none
interface fmssn_out_if;
    import fmssn_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [MANT_W-1:0]       res_word0;
    logic [MANT_W-1:0]       res_word1;
    logic [MANT_W-1:0]       res_word2;
    logic [MANT_W-1:0]       res_word3;
    logic                    sticky_out;
    logic signed [EXP_W-1:0] exponent_out;
    logic                    zero_out;

    modport source (
        output valid, res_word0, res_word1, res_word2, res_word3,
               sticky_out, exponent_out, zero_out,
        input  ready
    );
    modport sink (
        input  valid, res_word0, res_word1, res_word2, res_word3,
               sticky_out, exponent_out, zero_out,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/core/fmssn_lead_det.sv
// Leading-one detector for the top mantissa word.
`timescale 1ns / 1ps
`default_nettype none
module fmssn_lead_det (
    input  wire logic [fmssn_pkg::MANT_W-1:0] i_word,
    output logic [fmssn_pkg::SH_W-1:0]        o_pos
);
    import fmssn_pkg::*;

    // Highest set bit wins; an all-zero word reports position 0
    always_comb begin
        o_pos = '0;
        for (int i = 0; i < MANT_W; i++) begin
            if (i_word[i]) begin
                o_pos = SH_W'(i);
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/fp_mantissa_sticky_shift_normalize.sv
// Top level: three-stage sticky right shifter and normalizer.
//
//  channel  dir  handshake      payload
//  i_in     in   valid / ready  req_type, shift_amount, mant_word0..3,
//                               sticky_in, exponent_in
//  o_out    out  valid / ready  res_word0..3, sticky_out, exponent_out, zero_out
//
// One beat per cycle in, one per cycle out while the output is not stalled; a beat
// passes the three pipeline registers (word shift, bit shift / leading-one search,
// normalize shift and exponent saturation).
// Reset (i_rst_n, synchronous, active low) clears the stage valid bits only.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// fill up and a stalled output holds its beat without loss or repeat.
`timescale 1ns / 1ps
`default_nettype none
module fp_mantissa_sticky_shift_normalize #(
    parameter int MANT_BITS = fmssn_pkg::MANT_BITS_DEF,
    parameter int LEAD_BIT  = fmssn_pkg::LEAD_BIT_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fmssn_in_if.sink    i_in,
    fmssn_out_if.source o_out
);
    import fmssn_pkg::*;

    localparam logic [7:0]                  BIG_SHIFT  = 8'(MANT_BITS);
    localparam logic [SH_W-1:0]             LEAD_POS   = SH_W'(LEAD_BIT);
    localparam logic signed [EXP_INT_W-1:0] WORD_STEP  = EXP_INT_W'(MANT_W);
    localparam logic signed [EXP_INT_W-1:0] WORD_STEP2 = EXP_INT_W'(2 * MANT_W);
    localparam logic signed [EXP_INT_W-1:0] WORD_STEP3 = EXP_INT_W'(3 * MANT_W);
    localparam logic signed [EXP_INT_W-1:0] EXP_MAX   = EXP_INT_W'(2 ** (EXP_W - 1) - 1);
    localparam logic signed [EXP_INT_W-1:0] EXP_MIN   = -EXP_INT_W'(2 ** (EXP_W - 1));

    logic   r_v1, r_v2, r_v3;
    t_stage r_s1, r_s2, r_s3;
    t_stage n_s1, n_s2, n_s3;
    logic   w_en1, w_en2, w_en3;

    logic [MANT_TOT-1:0]         w_in_mant;
    logic signed [EXP_INT_W-1:0] w_exp_in;
    logic [SH_W-1:0]             w_pos;
    logic [MANT_W-1:0]           w_low_mask;
    logic signed [EXP_INT_W-1:0] w_sat;

    // Stage enables: a stage moves when empty or when its successor moves
    assign w_en3      = !r_v3 || o_out.ready;
    assign w_en2      = !r_v2 || w_en3;
    assign w_en1      = !r_v1 || w_en2;
    assign i_in.ready = w_en1;

    assign w_in_mant = {i_in.mant_word0, i_in.mant_word1, i_in.mant_word2, i_in.mant_word3};
    assign w_exp_in  = EXP_INT_W'(i_in.exponent_in);

    // Stage 1: whole-word shift, dropped-word sticky, zero detect
    always_comb begin
        n_s1        = '0;
        n_s1.req    = t_req'(i_in.req_type);
        n_s1.exp    = w_exp_in;
        n_s1.sticky = i_in.sticky_in;
        n_s1.mant   = w_in_mant;
        if (n_s1.req == REQ_SHIFT) begin
            n_s1.shamt = i_in.shift_amount[SH_W-1:0];
            if (i_in.shift_amount >= BIG_SHIFT) begin
                n_s1.mant   = '0;
                n_s1.sticky = 1'b1;
            end else begin
                case (i_in.shift_amount[6:5])
                    2'd1: begin
                        n_s1.mant   = w_in_mant >> MANT_W;
                        n_s1.sticky = i_in.sticky_in || (i_in.mant_word3 != '0);
                    end
                    2'd2: begin
                        n_s1.mant   = w_in_mant >> (2 * MANT_W);
                        n_s1.sticky = i_in.sticky_in || (i_in.mant_word3 != '0)
                                      || (i_in.mant_word2 != '0);
                    end
                    2'd3: begin
                        n_s1.mant   = w_in_mant >> (3 * MANT_W);
                        n_s1.sticky = i_in.sticky_in || (i_in.mant_word3 != '0)
                                      || (i_in.mant_word2 != '0)
                                      || (i_in.mant_word1 != '0);
                    end
                    default: begin
                        n_s1.mant = w_in_mant;
                    end
                endcase
            end
        end else begin
            if (i_in.mant_word0 != '0) begin
                n_s1.mant = w_in_mant;
            end else if (i_in.mant_word1 != '0) begin
                n_s1.mant = w_in_mant << MANT_W;
                n_s1.exp  = w_exp_in - WORD_STEP;
            end else if (i_in.mant_word2 != '0) begin
                n_s1.mant = w_in_mant << (2 * MANT_W);
                n_s1.exp  = w_exp_in - WORD_STEP2;
            end else if (i_in.mant_word3 != '0) begin
                n_s1.mant = w_in_mant << (3 * MANT_W);
                n_s1.exp  = w_exp_in - WORD_STEP3;
            end else begin
                n_s1.zero = 1'b1;
            end
        end
    end

    fmssn_lead_det u_lead_det (
        .i_word (r_s1.mant[MANT_TOT-1 -: MANT_W]),
        .o_pos  (w_pos)
    );

    assign w_low_mask = ~({MANT_W{1'b1}} << r_s1.shamt);

    // Stage 2: bit shift with sticky for shift mode, lead distance for normalize
    always_comb begin
        n_s2 = r_s1;
        if (r_s1.req == REQ_SHIFT) begin
            n_s2.mant   = r_s1.mant >> r_s1.shamt;
            n_s2.sticky = r_s1.sticky || ((r_s1.mant[MANT_W-1:0] & w_low_mask) != '0);
        end else if (!r_s1.zero) begin
            n_s2.right = w_pos > LEAD_POS;
            n_s2.shamt = (w_pos > LEAD_POS) ? (w_pos - LEAD_POS) : (LEAD_POS - w_pos);
            n_s2.exp   = r_s1.exp + EXP_INT_W'(w_pos) - EXP_INT_W'(LEAD_POS);
        end
    end

    // Exponent saturation to the port range
    always_comb begin
        if (r_s2.exp > EXP_MAX) begin
            w_sat = EXP_MAX;
        end else if (r_s2.exp < EXP_MIN) begin
            w_sat = EXP_MIN;
        end else begin
            w_sat = r_s2.exp;
        end
    end

    // Stage 3: normalize shift; the lowest word is dropped on a right move
    always_comb begin
        n_s3     = r_s2;
        n_s3.exp = w_sat;
        if (r_s2.req == REQ_NORM && !r_s2.zero) begin
            if (r_s2.right) begin
                n_s3.mant = {r_s2.mant[MANT_TOT-1:MANT_W], {MANT_W{1'b0}}} >> r_s2.shamt;
            end else begin
                n_s3.mant = r_s2.mant << r_s2.shamt;
            end
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_in.valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (w_en1 && i_in.valid) r_s1 <= n_s1;
        if (w_en2 && r_v1)       r_s2 <= n_s2;
        if (w_en3 && r_v2)       r_s3 <= n_s3;
    end

    // Output beat
    assign o_out.valid        = r_v3;
    assign o_out.res_word0    = r_s3.mant[4*MANT_W-1 -: MANT_W];
    assign o_out.res_word1    = r_s3.mant[3*MANT_W-1 -: MANT_W];
    assign o_out.res_word2    = r_s3.mant[2*MANT_W-1 -: MANT_W];
    assign o_out.res_word3    = r_s3.mant[MANT_W-1:0];
    assign o_out.sticky_out   = r_s3.sticky;
    assign o_out.exponent_out = r_s3.exp[EXP_W-1:0];
    assign o_out.zero_out     = r_s3.zero;

    // An accepted input beat always lands in stage 1
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_v1)
        else $error("accepted beat not captured in stage 1");

    // A zero result carries an all-zero mantissa
    a_zero_mant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.zero_out) |-> (r_s3.mant == '0))
        else $error("zero flag with nonzero mantissa");

    // Shift mode never raises the zero flag
    a_shift_no_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_s3.req == REQ_SHIFT) |-> !o_out.zero_out)
        else $error("zero flag in shift mode");

    // A normalized nonzero result has its leading one at the lead position
    a_norm_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_s3.req == REQ_NORM && !o_out.zero_out)
        |-> ((o_out.res_word0 >> LEAD_POS) == MANT_W'(1)))
        else $error("normalized result not aligned");
endmodule
`default_nettype wire
